### src/fault_injecting_bit_memory_unit_assert.svh
// ----------------------------------------------------------------------------
// Fault-injecting bit memory: assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FAULT_INJECTING_BIT_MEMORY_UNIT_ASSERT_SVH
`define FAULT_INJECTING_BIT_MEMORY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FIBM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fibm assertion failed");
`define FIBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fibm assertion failed");
`else
`define FIBM_ASSERT(lbl, cond)
`define FIBM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/fibm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault-injecting bit memory: package
// Sizes, operation and fault codes, table entry and RAM request types.
// ----------------------------------------------------------------------------
package fibm_pkg;

    localparam int MEM_DEPTH  = 1024;
    localparam int MAX_FAULTS = 16;
    localparam int ADDR_W     = 10;
    localparam int CELL_AW    = $clog2(MEM_DEPTH);
    localparam int FT_AW      = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1;
    localparam int CNT_W      = $clog2(MAX_FAULTS + 1);

    localparam logic [2:0] OP_READ       = 3'd0;
    localparam logic [2:0] OP_WRITE      = 3'd1;
    localparam logic [2:0] OP_ADD        = 3'd2;
    localparam logic [2:0] OP_CLR_FAULTS = 3'd3;
    localparam logic [2:0] OP_CLR_MEM    = 3'd4;

    localparam logic [3:0] K_ALIAS    = 4'd0;
    localparam logic [3:0] K_BLOCK    = 4'd1;
    localparam logic [3:0] K_SAF0     = 4'd2;
    localparam logic [3:0] K_SAF1     = 4'd3;
    localparam logic [3:0] K_RDFLIP   = 4'd4;
    localparam logic [3:0] K_RDRESET0 = 4'd5;
    localparam logic [3:0] K_TF01     = 4'd6;
    localparam logic [3:0] K_TF10     = 4'd7;
    localparam logic [3:0] K_MIRROR   = 4'd8;
    localparam logic [3:0] K_CFINV    = 4'd9;
    localparam logic [3:0] K_WDFLIP   = 4'd10;
    localparam logic [3:0] K_CF0      = 4'd11;
    localparam logic [3:0] K_CF1      = 4'd12;
    localparam logic [3:0] K_CFIDEM   = 4'd13;

    typedef struct packed {
        logic [3:0]        kind;
        logic [ADDR_W-1:0] victim;
        logic [ADDR_W-1:0] aux;
    } fault_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [CELL_AW-1:0] addr;
        logic               wdata;
    } cell_req_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [FT_AW-1:0] addr;
        fault_t           wdata;
    } ft_req_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALIAS,
        S_CHECK,
        S_CELL_RD,
        S_CELL_EV,
        S_MIRROR,
        S_CPL_TBL,
        S_CPL_EV,
        S_CPL_WR,
        S_DONE
    } state_t;

    function automatic logic in_range(input logic [ADDR_W-1:0] a);
        return (32'(a) < 32'(MEM_DEPTH));
    endfunction

endpackage

### src/fibm_cell_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault-injecting bit memory: cell array
// One-bit-wide synchronous RAM with one access per cycle and registered read.
// ----------------------------------------------------------------------------
module fibm_cell_ram
(
    input  logic               clk,
    input  fibm_pkg::cell_req_t req,
    output logic               rdata
);

    logic mem [fibm_pkg::MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

### src/fibm_fault_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault-injecting bit memory: fault table
// Synchronous RAM of fault entries; the read data holds until the next read.
// ----------------------------------------------------------------------------
module fibm_fault_ram
(
    input  logic              clk,
    input  fibm_pkg::ft_req_t req,
    output fibm_pkg::fault_t  rdata
);

    fibm_pkg::fault_t mem [fibm_pkg::MAX_FAULTS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

### src/fault_injecting_bit_memory_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault-injecting bit memory unit
// One-bit memory with a table of injected faults, driven by a sequencer.
//
//   channel   direction   handshake             payload
//   input     in          in_valid / in_ready   op, address, write_value,
//                                               fault_kind, fault_aux
//   result    out         out_valid / out_ready read_data, status
//
// Add, clear-faults and unused operations go from idle straight to the done
// state. A read or write scans the fault table once for aliases and, if the
// resolved address is in range, once for checks; a write that passes the
// checks adds a mirror scan and a coupling pass over the table entries.
// After reset, and for each clear-memory operation, a clearing pass writes
// every cell, and no transaction is accepted meanwhile.
// A stalled result waits in the output register; the next transaction is
// accepted once the sequencer is idle again.
// ----------------------------------------------------------------------------
module fault_injecting_bit_memory_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  op,
    input  logic [fibm_pkg::ADDR_W-1:0] address,
    input  logic                        write_value,
    input  logic [3:0]                  fault_kind,
    input  logic [fibm_pkg::ADDR_W-1:0] fault_aux,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        read_data,
    output logic                        status
);

`include "fault_injecting_bit_memory_unit_assert.svh"

    fibm_pkg::state_t state_reg, state_next;
    logic [fibm_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [fibm_pkg::CNT_W-1:0]   idx_reg, idx_next, idx_inc;
    logic                         pend_reg, pend_next;
    logic [fibm_pkg::CELL_AW-1:0] clr_reg, clr_next;
    logic                         clr_res_reg, clr_res_next;
    logic                         out_valid_reg, out_valid_next;

    logic [2:0]                  op_reg, op_next;
    logic [fibm_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [fibm_pkg::ADDR_W-1:0] res_reg, res_next;
    logic                        wv_reg, wv_next;
    logic                        alias_reg, alias_next;
    logic                        blk_reg, blk_next;
    logic                        saf0_reg, saf0_next;
    logic                        saf1_reg, saf1_next;
    logic                        tf01_reg, tf01_next;
    logic                        tf10_reg, tf10_next;
    logic                        dforce_reg, dforce_next;
    logic                        dval_reg, dval_next;
    logic                        dinv_reg, dinv_next;
    logic                        rd_reg, rd_next;
    logic                        st_reg, st_next;
    logic                        rd_out_reg, rd_out_next;
    logic                        st_out_reg, st_out_next;

    fibm_pkg::cell_req_t cell_req;
    fibm_pkg::ft_req_t   ft_req;
    logic                cell_rdata;
    fibm_pkg::fault_t    ft_rdata;

    logic accept, scan_state, scan_issue, scan_done, load_out;
    logic hit_res, hit_addr, aux_ok, cpl_kind, read_ok, write_ok, last_entry;

    fibm_cell_ram u_cell_ram
    (
        .clk   (clk),
        .req   (cell_req),
        .rdata (cell_rdata)
    );

    fibm_fault_ram u_fault_ram
    (
        .clk   (clk),
        .req   (ft_req),
        .rdata (ft_rdata)
    );

    assign in_ready   = (state_reg == fibm_pkg::S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign read_data  = rd_out_reg;
    assign status     = st_out_reg;

    assign scan_state = (state_reg == fibm_pkg::S_ALIAS) || (state_reg == fibm_pkg::S_CHECK)
                        || (state_reg == fibm_pkg::S_MIRROR);
    assign scan_issue = scan_state && (idx_reg < count_reg);
    assign scan_done  = !pend_reg && (idx_reg == count_reg);
    assign idx_inc    = idx_reg + 1'b1;
    assign last_entry = (idx_inc == count_reg);
    assign load_out   = (state_reg == fibm_pkg::S_DONE) && (!out_valid_reg || out_ready);

    assign hit_res  = (ft_rdata.victim == res_reg);
    assign hit_addr = (ft_rdata.victim == addr_reg);
    assign aux_ok   = fibm_pkg::in_range(ft_rdata.aux);
    assign cpl_kind = (ft_rdata.kind == fibm_pkg::K_CFINV) || (ft_rdata.kind == fibm_pkg::K_WDFLIP)
                      || (ft_rdata.kind == fibm_pkg::K_CF0) || (ft_rdata.kind == fibm_pkg::K_CF1)
                      || (ft_rdata.kind == fibm_pkg::K_CFIDEM);
    assign read_ok  = !blk_reg && !saf0_reg && !saf1_reg;
    assign write_ok = !blk_reg && !(wv_reg && tf01_reg) && !(!wv_reg && tf10_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fibm_pkg::S_CLEAR:
            begin
                if (clr_reg == fibm_pkg::CELL_AW'(fibm_pkg::MEM_DEPTH - 1))
                begin
                    state_next = clr_res_reg ? fibm_pkg::S_DONE : fibm_pkg::S_IDLE;
                end
            end
            fibm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        fibm_pkg::OP_READ, fibm_pkg::OP_WRITE: state_next = fibm_pkg::S_ALIAS;
                        fibm_pkg::OP_CLR_MEM:                  state_next = fibm_pkg::S_CLEAR;
                        default:                               state_next = fibm_pkg::S_DONE;
                    endcase
                end
            end
            fibm_pkg::S_ALIAS:
            begin
                if (scan_done)
                begin
                    state_next = fibm_pkg::in_range(res_reg) ? fibm_pkg::S_CHECK
                                                              : fibm_pkg::S_DONE;
                end
            end
            fibm_pkg::S_CHECK:
            begin
                if (scan_done)
                begin
                    if (op_reg == fibm_pkg::OP_READ)
                    begin
                        state_next = read_ok ? fibm_pkg::S_CELL_RD : fibm_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = write_ok ? fibm_pkg::S_CELL_RD : fibm_pkg::S_DONE;
                    end
                end
            end
            fibm_pkg::S_CELL_RD:
            begin
                state_next = (op_reg == fibm_pkg::OP_READ) ? fibm_pkg::S_CELL_EV
                                                           : fibm_pkg::S_MIRROR;
            end
            fibm_pkg::S_CELL_EV:
            begin
                state_next = fibm_pkg::S_DONE;
            end
            fibm_pkg::S_MIRROR:
            begin
                if (scan_done)
                begin
                    state_next = (count_reg == '0) ? fibm_pkg::S_DONE : fibm_pkg::S_CPL_TBL;
                end
            end
            fibm_pkg::S_CPL_TBL:
            begin
                state_next = fibm_pkg::S_CPL_EV;
            end
            fibm_pkg::S_CPL_EV:
            begin
                if (hit_res && aux_ok && cpl_kind)
                begin
                    state_next = fibm_pkg::S_CPL_WR;
                end
                else
                begin
                    state_next = last_entry ? fibm_pkg::S_DONE : fibm_pkg::S_CPL_TBL;
                end
            end
            fibm_pkg::S_CPL_WR:
            begin
                state_next = last_entry ? fibm_pkg::S_DONE : fibm_pkg::S_CPL_TBL;
            end
            fibm_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    state_next = fibm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fibm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        clr_next       = clr_reg;
        clr_res_next   = clr_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_next        = op_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        wv_next        = wv_reg;
        alias_next     = alias_reg;
        blk_next       = blk_reg;
        saf0_next      = saf0_reg;
        saf1_next      = saf1_reg;
        tf01_next      = tf01_reg;
        tf10_next      = tf10_reg;
        dforce_next    = dforce_reg;
        dval_next      = dval_reg;
        dinv_next      = dinv_reg;
        rd_next        = rd_reg;
        st_next        = st_reg;
        rd_out_next    = rd_out_reg;
        st_out_next    = st_out_reg;
        cell_req       = '0;
        ft_req         = '0;

        if (scan_issue)
        begin
            ft_req.re   = 1'b1;
            ft_req.addr = idx_reg[fibm_pkg::FT_AW-1:0];
            idx_next    = idx_inc;
            pend_next   = 1'b1;
        end

        case (state_reg)
            fibm_pkg::S_CLEAR:
            begin
                cell_req.we   = 1'b1;
                cell_req.addr = clr_reg;
                clr_next      = clr_reg + 1'b1;
            end
            fibm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op;
                    addr_next    = address;
                    res_next     = address;
                    wv_next      = write_value;
                    alias_next   = 1'b0;
                    blk_next     = 1'b0;
                    saf0_next    = 1'b0;
                    saf1_next    = 1'b0;
                    tf01_next    = 1'b0;
                    tf10_next    = 1'b0;
                    dforce_next  = 1'b0;
                    dval_next    = 1'b0;
                    dinv_next    = 1'b0;
                    rd_next      = 1'b0;
                    st_next      = 1'b0;
                    idx_next     = '0;
                    clr_next     = '0;
                    clr_res_next = 1'b1;
                    case (op)
                        fibm_pkg::OP_ADD:
                        begin
                            if (count_reg >= fibm_pkg::CNT_W'(fibm_pkg::MAX_FAULTS))
                            begin
                                st_next = 1'b1;
                            end
                            else
                            begin
                                ft_req.we           = 1'b1;
                                ft_req.addr         = count_reg[fibm_pkg::FT_AW-1:0];
                                ft_req.wdata.kind   = fault_kind;
                                ft_req.wdata.victim = address;
                                ft_req.wdata.aux    = fault_aux;
                                count_next          = count_reg + 1'b1;
                            end
                        end
                        fibm_pkg::OP_CLR_FAULTS:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fibm_pkg::S_ALIAS:
            begin
                if (pend_reg && !alias_reg && hit_addr && ft_rdata.kind == fibm_pkg::K_ALIAS)
                begin
                    alias_next = 1'b1;
                    res_next   = ft_rdata.aux;
                end
                if (scan_done)
                begin
                    idx_next = '0;
                end
            end
            fibm_pkg::S_CHECK:
            begin
                if (pend_reg && hit_res)
                begin
                    case (ft_rdata.kind)
                        fibm_pkg::K_BLOCK: blk_next  = 1'b1;
                        fibm_pkg::K_SAF0:  saf0_next = 1'b1;
                        fibm_pkg::K_SAF1:  saf1_next = 1'b1;
                        fibm_pkg::K_TF01:  tf01_next = 1'b1;
                        fibm_pkg::K_TF10:  tf10_next = 1'b1;
                        fibm_pkg::K_RDFLIP:
                        begin
                            if (dforce_reg)
                            begin
                                dval_next = !dval_reg;
                            end
                            else
                            begin
                                dinv_next = !dinv_reg;
                            end
                        end
                        fibm_pkg::K_RDRESET0:
                        begin
                            dforce_next = 1'b1;
                            dval_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (scan_done && op_reg == fibm_pkg::OP_READ && !blk_reg && !saf0_reg)
                begin
                    rd_next = saf1_reg;
                end
            end
            fibm_pkg::S_CELL_RD:
            begin
                cell_req.addr = res_reg[fibm_pkg::CELL_AW-1:0];
                if (op_reg == fibm_pkg::OP_READ)
                begin
                    cell_req.re = 1'b1;
                end
                else
                begin
                    cell_req.we    = 1'b1;
                    cell_req.wdata = wv_reg;
                    idx_next       = '0;
                end
            end
            fibm_pkg::S_CELL_EV:
            begin
                rd_next        = cell_rdata;
                cell_req.we    = dforce_reg || dinv_reg;
                cell_req.addr  = res_reg[fibm_pkg::CELL_AW-1:0];
                cell_req.wdata = dforce_reg ? dval_reg : (cell_rdata ^ dinv_reg);
            end
            fibm_pkg::S_MIRROR:
            begin
                if (pend_reg && hit_res && aux_ok && ft_rdata.kind == fibm_pkg::K_MIRROR)
                begin
                    cell_req.we    = 1'b1;
                    cell_req.addr  = ft_rdata.aux[fibm_pkg::CELL_AW-1:0];
                    cell_req.wdata = wv_reg;
                end
                if (scan_done)
                begin
                    idx_next = '0;
                end
            end
            fibm_pkg::S_CPL_TBL:
            begin
                ft_req.re   = 1'b1;
                ft_req.addr = idx_reg[fibm_pkg::FT_AW-1:0];
            end
            fibm_pkg::S_CPL_EV:
            begin
                if (hit_res && aux_ok && cpl_kind)
                begin
                    cell_req.re   = 1'b1;
                    cell_req.addr = ft_rdata.aux[fibm_pkg::CELL_AW-1:0];
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            fibm_pkg::S_CPL_WR:
            begin
                cell_req.we   = 1'b1;
                cell_req.addr = ft_rdata.aux[fibm_pkg::CELL_AW-1:0];
                case (ft_rdata.kind)
                    fibm_pkg::K_CF0:    cell_req.wdata = 1'b0;
                    fibm_pkg::K_CF1:    cell_req.wdata = 1'b1;
                    fibm_pkg::K_CFIDEM: cell_req.wdata = wv_reg;
                    default:            cell_req.wdata = !cell_rdata;
                endcase
                idx_next = idx_inc;
            end
            fibm_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    rd_out_next    = rd_reg;
                    st_out_next    = st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fibm_pkg::S_CLEAR;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
            clr_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            clr_reg       <= clr_next;
            clr_res_reg   <= clr_res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        res_reg    <= res_next;
        wv_reg     <= wv_next;
        alias_reg  <= alias_next;
        blk_reg    <= blk_next;
        saf0_reg   <= saf0_next;
        saf1_reg   <= saf1_next;
        tf01_reg   <= tf01_next;
        tf10_reg   <= tf10_next;
        dforce_reg <= dforce_next;
        dval_reg   <= dval_next;
        dinv_reg   <= dinv_next;
        rd_reg     <= rd_next;
        st_reg     <= st_next;
        rd_out_reg <= rd_out_next;
        st_out_reg <= st_out_next;
    end

    // The fill count never passes the table size, and the table is never written when full.
    `FIBM_ASSERT(a_count_bound, count_reg <= fibm_pkg::CNT_W'(fibm_pkg::MAX_FAULTS))
    `FIBM_ASSERT(a_no_write_full, !ft_req.we || count_reg < fibm_pkg::CNT_W'(fibm_pkg::MAX_FAULTS))
    // An accepted transaction always takes the sequencer out of idle.
    `FIBM_ASSERT_NEXT(a_leave_idle, accept, state_reg != fibm_pkg::S_IDLE)

endmodule

### tb/sv/fibm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault-injecting bit memory: result checker
// Watches both channels and predicts the memory with its fault table.
// Each accepted result is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module fibm_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [2:0]                  op,
    input  logic [fibm_pkg::ADDR_W-1:0] address,
    input  logic                        write_value,
    input  logic [3:0]                  fault_kind,
    input  logic [fibm_pkg::ADDR_W-1:0] fault_aux,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        read_data,
    input  logic                        status,
    output int                          errors,
    output int                          pending
);
    import fibm_pkg::*;

    typedef struct packed {
        logic rd;
        logic st;
    } outcome_t;

    logic   mem_bits [MEM_DEPTH];
    fault_t faults [MAX_FAULTS];
    int     n_faults;
    outcome_t outcomes [$];

    function automatic int map_alias(input int a);
        for (int i = 0; i < n_faults; i++)
            if (faults[i].kind == K_ALIAS && int'(faults[i].victim) == a)
                return int'(faults[i].aux);
        return a;
    endfunction

    function automatic logic faulted(input int a, input logic [3:0] k);
        for (int i = 0; i < n_faults; i++)
            if (faults[i].kind == k && int'(faults[i].victim) == a)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic model_read(input int addr);
        int a;
        logic v;
        a = map_alias(addr);
        if (a >= MEM_DEPTH || faulted(a, K_BLOCK) || faulted(a, K_SAF0))
            return 1'b0;
        if (faulted(a, K_SAF1))
            return 1'b1;
        v = mem_bits[a];
        for (int i = 0; i < n_faults; i++)
        begin
            if (int'(faults[i].victim) != a)
                continue;
            if (faults[i].kind == K_RDFLIP)
                mem_bits[a] = ~mem_bits[a];
            else if (faults[i].kind == K_RDRESET0)
                mem_bits[a] = 1'b0;
        end
        return v;
    endfunction

    function automatic void model_write(input int addr, input logic v);
        int a;
        int x;
        a = map_alias(addr);
        if (a >= MEM_DEPTH || faulted(a, K_BLOCK))
            return;
        if (v && faulted(a, K_TF01))
            return;
        if (!v && faulted(a, K_TF10))
            return;
        mem_bits[a] = v;
        for (int i = 0; i < n_faults; i++)
        begin
            x = int'(faults[i].aux);
            if (faults[i].kind == K_MIRROR && int'(faults[i].victim) == a && x < MEM_DEPTH)
                mem_bits[x] = v;
        end
        for (int i = 0; i < n_faults; i++)
        begin
            x = int'(faults[i].aux);
            if (int'(faults[i].victim) != a || x >= MEM_DEPTH)
                continue;
            case (faults[i].kind)
                K_CFINV, K_WDFLIP: mem_bits[x] = ~mem_bits[x];
                K_CF0:             mem_bits[x] = 1'b0;
                K_CF1:             mem_bits[x] = 1'b1;
                K_CFIDEM:          mem_bits[x] = v;
                default:           ;
            endcase
        end
    endfunction

    assign pending = outcomes.size();

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        outcome_t e;
        if (!rst_n)
        begin
            foreach (mem_bits[i])
                mem_bits[i] = 1'b0;
            n_faults = 0;
            errors   = 0;
            outcomes.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                o = '0;
                case (op)
                    OP_READ:  o.rd = model_read(int'(address));
                    OP_WRITE: model_write(int'(address), write_value);
                    OP_ADD:
                        if (n_faults >= MAX_FAULTS)
                            o.st = 1'b1;
                        else
                        begin
                            faults[n_faults] = '{fault_kind, address, fault_aux};
                            n_faults++;
                        end
                    OP_CLR_FAULTS: n_faults = 0;
                    OP_CLR_MEM:
                        foreach (mem_bits[i])
                            mem_bits[i] = 1'b0;
                    default: ;
                endcase
                outcomes = {outcomes, o};
            end
            if (out_valid && out_ready)
            begin
                if (outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result rd=%b st=%b", $time, read_data, status);
                    errors++;
                end
                else
                begin
                    e = outcomes.pop_front();
                    if (read_data !== e.rd)
                    begin
                        $display("%0t: read_data expected %b actual %b", $time, e.rd, read_data);
                        errors++;
                    end
                    if (status !== e.st)
                    begin
                        $display("%0t: status expected %b actual %b", $time, e.st, status);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault-injecting bit memory: testbench top
// Drives directed and random transactions with random gaps and stalls,
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top;
    import fibm_pkg::*;

    localparam int WATCHDOG = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] op = '0;
    logic [ADDR_W-1:0] address = '0;
    logic       write_value = 1'b0;
    logic [3:0] fault_kind = '0;
    logic [ADDR_W-1:0] fault_aux = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       read_data;
    logic       status;
    int         errors;
    int         pending;
    int         idle_cycles = 0;

    always #5 clk = ~clk;

    fault_injecting_bit_memory_unit u_dut (.*);

    fibm_checker u_chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int stall;
        forever
        begin
            @(posedge clk);
            stall = gap_len();
            if (stall == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [2:0] o, input int a, input logic v,
                        input logic [3:0] k, input int x);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        address     <= a[ADDR_W-1:0];
        write_value <= v;
        fault_kind  <= k;
        fault_aux   <= x[ADDR_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Localised addresses so that faults actually hit the accessed cells.
    function automatic int pick_addr();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 1023);
        return $urandom_range(0, 7);
    endfunction

    initial
    begin
        int r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_WRITE, 1023, 1'b1, 4'd0, 0);
        send(OP_READ, 1023, 1'b0, 4'd15, 1023);
        send(OP_WRITE, 0, 1'b1, 4'd0, 0);
        send(OP_ADD, 5, 1'b0, K_ALIAS, 0);
        send(OP_READ, 5, 1'b0, 4'd0, 0);
        send(OP_ADD, 1, 1'b0, K_SAF0, 0);
        send(OP_ADD, 1, 1'b0, K_SAF1, 0);
        send(OP_READ, 1, 1'b0, 4'd0, 0);
        send(OP_ADD, 2, 1'b0, K_RDFLIP, 0);
        send(OP_WRITE, 2, 1'b1, 4'd0, 0);
        send(OP_READ, 2, 1'b0, 4'd0, 0);
        send(OP_READ, 2, 1'b0, 4'd0, 0);
        send(OP_ADD, 3, 1'b0, K_MIRROR, 1023);
        send(OP_ADD, 3, 1'b0, K_CFIDEM, 4);
        send(OP_WRITE, 3, 1'b1, 4'd0, 0);
        send(OP_READ, 1023, 1'b0, 4'd0, 0);
        for (int i = 0; i < 12; i++)
            send(OP_ADD, i, 1'b0, 4'($urandom_range(0, 15)), $urandom_range(0, 1023));
        send(OP_READ, 4, 1'b0, 4'd0, 0);
        send(OP_CLR_MEM, 0, 1'b0, 4'd0, 0);
        send(3'd7, 1023, 1'b1, 4'd15, 1023);
        send(OP_CLR_FAULTS, 0, 1'b0, 4'd0, 0);

        for (int n = 0; n < 1100; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send(OP_READ, pick_addr(), 1'($urandom), 4'($urandom), $urandom);
            else if (r < 70)
                send(OP_WRITE, pick_addr(), 1'($urandom), 4'($urandom), $urandom);
            else if (r < 90)
                send(OP_ADD, pick_addr(), 1'($urandom),
                     4'($urandom_range(0, 15)),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 7));
            else if (r < 95)
                send(OP_CLR_FAULTS, $urandom, 1'($urandom), 4'($urandom), $urandom);
            else if (r < 97)
                send(OP_CLR_MEM, $urandom, 1'($urandom), 4'($urandom), $urandom);
            else
                send(3'($urandom_range(5, 7)), $urandom, 1'($urandom), 4'($urandom),
                     $urandom);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && !out_valid)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
